@@ design/cau_pkg.sv @@
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef logic [1:0] op_t;

    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_DIV = 2'd3;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic neg_r;
        logic neg_i;
        logic big_r;
        logic big_i;
        logic dz;
    } ctrl_t;

endpackage

@@ design/cau_front.sv @@
module cau_front #(
    parameter int DW = 16,
    parameter int FB = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  cau_pkg::op_t               operation,
    input  logic signed [DW-1:0]       a_real,
    input  logic signed [DW-1:0]       a_imag,
    input  logic signed [DW-1:0]       b_real,
    input  logic signed [DW-1:0]       b_imag,
    output cau_pkg::ctrl_t             ctrl_o,
    output logic [2*DW+FB-1:0]         rem_r_o,
    output logic [2*DW+FB-1:0]         rem_i_o,
    output logic [DW-1:0]              q_r_o,
    output logic [DW-1:0]              q_i_o,
    output logic [2*DW-1:0]            den_o
);
    import cau_pkg::*;

    localparam int PW = 2 * DW;
    localparam int SW = 2 * DW + 1;
    localparam int RW = 2 * DW + FB;
    localparam int CW = 3 * DW + FB;

    logic                 a_valid_reg;
    op_t                  a_op_reg;
    logic signed [DW-1:0] a_ar_reg, a_ai_reg, a_br_reg, a_bi_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;

    ctrl_t           b_ctrl_reg, b_ctrl_next;
    logic [PW-1:0]   b_mag_r_reg, b_mag_i_reg, b_mag_r_next, b_mag_i_next;
    logic [PW-1:0]   b_den_reg, b_den_next;

    ctrl_t           c_ctrl_reg, c_ctrl_next;
    logic [RW-1:0]   c_rem_r_reg, c_rem_i_reg, c_rem_r_next, c_rem_i_next;
    logic [DW-1:0]   c_q_r_reg, c_q_i_reg, c_q_r_next, c_q_i_next;
    logic [PW-1:0]   c_den_reg;

    logic signed [SW-1:0] v_r, v_i, ext_ar, ext_ai, ext_br, ext_bi;
    logic [SW-1:0]        abs_r, abs_i;
    logic [RW-1:0]        x_r, x_i;
    logic [CW-1:0]        den_top;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_ctrl_reg  <= '0;
            c_ctrl_reg  <= '0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_ctrl_reg  <= b_ctrl_next;
            c_ctrl_reg  <= c_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg    <= operation;
            a_ar_reg    <= a_real;
            a_ai_reg    <= a_imag;
            a_br_reg    <= b_real;
            a_bi_reg    <= b_imag;
            p_rr_reg    <= a_real * b_real;
            p_ii_reg    <= a_imag * b_imag;
            p_ri_reg    <= a_real * b_imag;
            p_ir_reg    <= a_imag * b_real;
            sq_r_reg    <= b_real * b_real;
            sq_i_reg    <= b_imag * b_imag;
            b_mag_r_reg <= b_mag_r_next;
            b_mag_i_reg <= b_mag_i_next;
            b_den_reg   <= b_den_next;
            c_rem_r_reg <= c_rem_r_next;
            c_rem_i_reg <= c_rem_i_next;
            c_q_r_reg   <= c_q_r_next;
            c_q_i_reg   <= c_q_i_next;
            c_den_reg   <= b_den_reg;
        end
    end

    always_comb
    begin
        ext_ar = {{(SW-DW){a_ar_reg[DW-1]}}, a_ar_reg};
        ext_ai = {{(SW-DW){a_ai_reg[DW-1]}}, a_ai_reg};
        ext_br = {{(SW-DW){a_br_reg[DW-1]}}, a_br_reg};
        ext_bi = {{(SW-DW){a_bi_reg[DW-1]}}, a_bi_reg};
        case (a_op_reg)
            OP_ADD:
            begin
                v_r = ext_ar + ext_br;
                v_i = ext_ai + ext_bi;
            end
            OP_SUB:
            begin
                v_r = ext_ar - ext_br;
                v_i = ext_ai - ext_bi;
            end
            OP_MUL:
            begin
                v_r = {p_rr_reg[PW-1], p_rr_reg} - {p_ii_reg[PW-1], p_ii_reg};
                v_i = {p_ri_reg[PW-1], p_ri_reg} + {p_ir_reg[PW-1], p_ir_reg};
            end
            default:
            begin
                v_r = {p_rr_reg[PW-1], p_rr_reg} + {p_ii_reg[PW-1], p_ii_reg};
                v_i = {p_ir_reg[PW-1], p_ir_reg} - {p_ri_reg[PW-1], p_ri_reg};
            end
        endcase
        abs_r = v_r[SW-1] ? SW'(-v_r) : SW'(v_r);
        abs_i = v_i[SW-1] ? SW'(-v_i) : SW'(v_i);
        b_mag_r_next = abs_r[PW-1:0];
        b_mag_i_next = abs_i[PW-1:0];
        if (a_op_reg == OP_MUL)
        begin
            b_mag_r_next = abs_r[PW-1:0] >> FB;
            b_mag_i_next = abs_i[PW-1:0] >> FB;
        end
        b_den_next        = sq_r_reg[PW-1:0] + sq_i_reg[PW-1:0];
        b_ctrl_next       = '0;
        b_ctrl_next.valid = a_valid_reg;
        b_ctrl_next.op    = a_op_reg;
        b_ctrl_next.neg_r = v_r[SW-1];
        b_ctrl_next.neg_i = v_i[SW-1];
        b_ctrl_next.dz    = (a_op_reg == OP_DIV) && (b_den_next == '0);
    end

    always_comb
    begin
        x_r         = RW'(b_mag_r_reg) << FB;
        x_i         = RW'(b_mag_i_reg) << FB;
        den_top     = CW'(b_den_reg) << DW;
        c_ctrl_next = b_ctrl_reg;
        if (b_ctrl_reg.op == OP_DIV)
        begin
            c_ctrl_next.big_r = CW'(x_r) >= den_top;
            c_ctrl_next.big_i = CW'(x_i) >= den_top;
            c_rem_r_next      = x_r;
            c_rem_i_next      = x_i;
            c_q_r_next        = '0;
            c_q_i_next        = '0;
        end
        else
        begin
            c_ctrl_next.big_r = |b_mag_r_reg[PW-1:DW];
            c_ctrl_next.big_i = |b_mag_i_reg[PW-1:DW];
            c_rem_r_next      = '0;
            c_rem_i_next      = '0;
            c_q_r_next        = b_mag_r_reg[DW-1:0];
            c_q_i_next        = b_mag_i_reg[DW-1:0];
        end
    end

    assign ctrl_o  = c_ctrl_reg;
    assign rem_r_o = c_rem_r_reg;
    assign rem_i_o = c_rem_i_reg;
    assign q_r_o   = c_q_r_reg;
    assign q_i_o   = c_q_i_reg;
    assign den_o   = c_den_reg;

endmodule

@@ design/cau_div_cell.sv @@
module cau_div_cell #(
    parameter int DW  = 16,
    parameter int FB  = 8,
    parameter int BIT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  cau_pkg::ctrl_t       ctrl_i,
    input  logic [2*DW+FB-1:0]   rem_r_i,
    input  logic [2*DW+FB-1:0]   rem_i_i,
    input  logic [DW-1:0]        q_r_i,
    input  logic [DW-1:0]        q_i_i,
    input  logic [2*DW-1:0]      den_i,
    output cau_pkg::ctrl_t       ctrl_o,
    output logic [2*DW+FB-1:0]   rem_r_o,
    output logic [2*DW+FB-1:0]   rem_i_o,
    output logic [DW-1:0]        q_r_o,
    output logic [DW-1:0]        q_i_o,
    output logic [2*DW-1:0]      den_o
);
    import cau_pkg::*;

    localparam int RW = 2 * DW + FB;
    localparam int CW = 3 * DW + FB;

    ctrl_t          ctrl_reg;
    logic [RW-1:0]  rem_r_reg, rem_i_reg, rem_r_next, rem_i_next;
    logic [DW-1:0]  q_r_reg, q_i_reg, q_r_next, q_i_next;
    logic [2*DW-1:0] den_reg;
    logic [CW-1:0]  dsh;

    always_comb
    begin
        dsh        = CW'(den_i) << BIT;
        rem_r_next = rem_r_i;
        rem_i_next = rem_i_i;
        q_r_next   = q_r_i;
        q_i_next   = q_i_i;
        if (ctrl_i.op == OP_DIV)
        begin
            if (CW'(rem_r_i) >= dsh)
            begin
                rem_r_next    = RW'(CW'(rem_r_i) - dsh);
                q_r_next[BIT] = 1'b1;
            end
            if (CW'(rem_i_i) >= dsh)
            begin
                rem_i_next    = RW'(CW'(rem_i_i) - dsh);
                q_i_next[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_r_reg <= rem_r_next;
            rem_i_reg <= rem_i_next;
            q_r_reg   <= q_r_next;
            q_i_reg   <= q_i_next;
            den_reg   <= den_i;
        end
    end

    assign ctrl_o  = ctrl_reg;
    assign rem_r_o = rem_r_reg;
    assign rem_i_o = rem_i_reg;
    assign q_r_o   = q_r_reg;
    assign q_i_o   = q_i_reg;
    assign den_o   = den_reg;

endmodule

@@ design/complex_arithmetic_unit.sv @@
// Complex add, subtract, multiply and divide on signed fixed-point operands. One transaction is
// accepted per clock cycle while in_ready is high; each result passes through three stages of
// products, sums and scaling (the first is loaded at the accepting edge), one restoring-division
// cell per quotient bit (DATA_WIDTH cells), and the output register. All operations share the
// same pipeline, so results leave in order; the whole pipeline holds while a result waits at the
// output.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cau_pkg::op_t                 operation,
    input  logic signed [DATA_WIDTH-1:0] a_real,
    input  logic signed [DATA_WIDTH-1:0] a_imag,
    input  logic signed [DATA_WIDTH-1:0] b_real,
    input  logic signed [DATA_WIDTH-1:0] b_imag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] res_real,
    output logic signed [DATA_WIDTH-1:0] res_imag,
    output logic                         saturated,
    output logic                         div_by_zero
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int RW = 2 * DW + FRAC_BITS;
    localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

    logic en;

    ctrl_t           ch_ctrl  [DW+1];
    logic [RW-1:0]   ch_rem_r [DW+1];
    logic [RW-1:0]   ch_rem_i [DW+1];
    logic [DW-1:0]   ch_q_r   [DW+1];
    logic [DW-1:0]   ch_q_i   [DW+1];
    logic [2*DW-1:0] ch_den   [DW+1];

    logic          out_valid_reg;
    logic [DW-1:0] res_real_reg, res_imag_reg, res_real_next, res_imag_next;
    logic          sat_reg, sat_next, dz_reg;
    logic          sat_r, sat_i;
    ctrl_t         fin;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    cau_front #(
        .DW(DW),
        .FB(FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .operation (operation),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .ctrl_o    (ch_ctrl[0]),
        .rem_r_o   (ch_rem_r[0]),
        .rem_i_o   (ch_rem_i[0]),
        .q_r_o     (ch_q_r[0]),
        .q_i_o     (ch_q_i[0]),
        .den_o     (ch_den[0])
    );

    for (genvar g = 0; g < DW; g++)
    begin : g_cell
        cau_div_cell #(
            .DW (DW),
            .FB (FRAC_BITS),
            .BIT(DW - 1 - g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctrl_i  (ch_ctrl[g]),
            .rem_r_i (ch_rem_r[g]),
            .rem_i_i (ch_rem_i[g]),
            .q_r_i   (ch_q_r[g]),
            .q_i_i   (ch_q_i[g]),
            .den_i   (ch_den[g]),
            .ctrl_o  (ch_ctrl[g+1]),
            .rem_r_o (ch_rem_r[g+1]),
            .rem_i_o (ch_rem_i[g+1]),
            .q_r_o   (ch_q_r[g+1]),
            .q_i_o   (ch_q_i[g+1]),
            .den_o   (ch_den[g+1])
        );
    end

    always_comb
    begin
        fin   = ch_ctrl[DW];
        sat_r = fin.big_r || (ch_q_r[DW] > NEG_MIN) || (!fin.neg_r && ch_q_r[DW] == NEG_MIN);
        sat_i = fin.big_i || (ch_q_i[DW] > NEG_MIN) || (!fin.neg_i && ch_q_i[DW] == NEG_MIN);
        if (sat_r)
        begin
            res_real_next = fin.neg_r ? NEG_MIN : POS_MAX;
        end
        else
        begin
            res_real_next = fin.neg_r ? DW'(-ch_q_r[DW]) : ch_q_r[DW];
        end
        if (sat_i)
        begin
            res_imag_next = fin.neg_i ? NEG_MIN : POS_MAX;
        end
        else
        begin
            res_imag_next = fin.neg_i ? DW'(-ch_q_i[DW]) : ch_q_i[DW];
        end
        sat_next = sat_r || sat_i;
        if (fin.dz)
        begin
            res_real_next = '0;
            res_imag_next = '0;
            sat_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_real_reg <= res_real_next;
            res_imag_reg <= res_imag_next;
            sat_reg      <= sat_next;
            dz_reg       <= fin.dz;
        end
    end

    assign out_valid   = out_valid_reg;
    assign res_real    = res_real_reg;
    assign res_imag    = res_imag_reg;
    assign saturated   = sat_reg;
    assign div_by_zero = dz_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> res_real == '0 && res_imag == '0 && !saturated)
        else $error("Divide by zero did not give a zero result.");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            res_real == POS_MAX || res_real == NEG_MIN ||
            res_imag == POS_MAX || res_imag == NEG_MIN)
        else $error("Saturation flag set without a clipped part.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("Pipeline advanced while the output was stalled.");

endmodule

@@ sim/tb.sv @@
module tb;

    import cau_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 sat;
        logic                 dz;
    } cplx_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    op_t                  operation = OP_ADD;
    logic signed [DW-1:0] a_real = '0;
    logic signed [DW-1:0] a_imag = '0;
    logic signed [DW-1:0] b_real = '0;
    logic signed [DW-1:0] b_imag = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [DW-1:0] res_real;
    logic signed [DW-1:0] res_imag;
    logic                 saturated;
    logic                 div_by_zero;

    cplx_result_t pending_results[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           burst_left = 0;

    complex_arithmetic_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .a_real     (a_real),
        .a_imag     (a_imag),
        .b_real     (b_real),
        .b_imag     (b_imag),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res_real   (res_real),
        .res_imag   (res_imag),
        .saturated  (saturated),
        .div_by_zero(div_by_zero)
    );

    always #6 clk = ~clk;

    function automatic logic signed [DW-1:0] clamp_part(input longint v, inout logic sat);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DW - 1)) - 1;
        lo = -(longint'(1) <<< (DW - 1));
        if (v > hi)
        begin
            sat = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    function automatic cplx_result_t compute_complex(input op_t op, input longint ar,
                                                     input longint ai, input longint br,
                                                     input longint bi);
        cplx_result_t r;
        longint       vr;
        longint       vi;
        longint       den;
        logic         sat;
        sat = 1'b0;
        r.dz = 1'b0;
        vr = 0;
        vi = 0;
        case (op)
            OP_ADD:
            begin
                vr = ar + br;
                vi = ai + bi;
            end
            OP_SUB:
            begin
                vr = ar - br;
                vi = ai - bi;
            end
            OP_MUL:
            begin
                vr = (ar * br - ai * bi) / (longint'(1) <<< FB);
                vi = (ar * bi + ai * br) / (longint'(1) <<< FB);
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    vr = ((ar * br + ai * bi) * (longint'(1) <<< FB)) / den;
                    vi = ((ai * br - ar * bi) * (longint'(1) <<< FB)) / den;
                end
            end
        endcase
        r.re = clamp_part(vr, sat);
        r.im = clamp_part(vi, sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_item(input op_t op, input logic signed [DW-1:0] ar,
                             input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                             input logic signed [DW-1:0] bi);
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        a_real <= ar;
        a_imag <= ai;
        b_real <= br;
        b_imag <= bi;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(compute_complex(op, ar, ai, br, bi));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 7))
                    @(negedge clk);
            end
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DW-1:0] rand_value(input int spread);
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = (($urandom_range(0, 1) != 0) ? 32767 : -32768);
            default: v = int'($urandom_range(0, 2 * spread)) - spread;
        endcase
        return v[DW-1:0];
    endfunction

    always @(negedge clk)
    begin
        case ((cycle_count / 200) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) != 0);
            2: out_ready <= ((cycle_count % 5) < 3);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("tb: transaction without a pending result");
                error_count++;
            end
            else
            begin
                cplx_result_t want;
                want = pending_results.pop_front();
                if (res_real !== want.re)
                    report_mismatch("res_real", res_real, want.re);
                if (res_imag !== want.im)
                    report_mismatch("res_imag", res_imag, want.im);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
                if (div_by_zero !== want.dz)
                    report_mismatch("div_by_zero", div_by_zero, want.dz);
            end
        end
    end

    task automatic test_add_sub_extremes();
        send_item(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0001);
        send_item(OP_ADD, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh0001);
        send_item(OP_ADD, 16'sh0100, -16'sh0080, 16'sh0000, 16'sh0000);
        send_item(OP_SUB, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff);
        send_item(OP_SUB, -16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(OP_SUB, 16'sh1234, 16'sh0040, 16'sh1234, 16'sh0040);
    endtask

    task automatic test_multiply();
        send_item(OP_MUL, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000);
        send_item(OP_MUL, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh0100);
        send_item(OP_MUL, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_item(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000);
        send_item(OP_MUL, -16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001);
        send_item(OP_MUL, 16'sh0003, -16'sh0005, 16'sh0007, 16'sh0002);
    endtask

    task automatic test_divide();
        send_item(OP_DIV, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000);
        send_item(OP_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0200);
        send_item(OP_DIV, 16'sh7fff, -16'sh8000, 16'sh0001, 16'sh0000);
        send_item(OP_DIV, -16'sh0001, 16'sh0000, 16'sh0300, 16'sh0000);
        send_item(OP_DIV, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_item(OP_DIV, 16'sh0001, 16'sh0001, 16'sh7fff, -16'sh8000);
    endtask

    task automatic test_divide_by_zero();
        send_item(OP_DIV, 16'sh7fff, -16'sh8000, 16'sh0000, 16'sh0000);
        send_item(OP_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(OP_DIV, -16'sh8000, 16'sh0123, 16'sh0000, 16'sh0000);
    endtask

    task automatic test_random(input int count);
        int spread;
        for (int n = 0; n < count; n++)
        begin
            spread = ($urandom_range(0, 1) != 0) ? 2048 : 32767;
            send_item(op_t'($urandom_range(0, 3)), rand_value(spread), rand_value(spread),
                      rand_value(spread), rand_value(spread));
            if (n == count / 2)
                wait_for_results();
        end
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_add_sub_extremes();
        test_multiply();
        test_divide();
        test_divide_by_zero();
        wait_for_results();
        test_random(1630);
        wait_for_results();
        repeat (40)
            @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ complex_arithmetic_unit.f @@
design/cau_pkg.sv
design/cau_front.sv
design/cau_div_cell.sv
design/complex_arithmetic_unit.sv
sim/tb.sv
